// File: sv/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg : shared types and constants for the min-priority queue
// Beat types, entry layout, status codes and the datapath command set.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // command kinds
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_EXTRACT = 2'd1;
    localparam logic [1:0] KIND_CHANGE  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_MIN   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key_value;
        logic [31:0]        target_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] min_key;
    } t_out;

    // one stored entry: tag of the pushing command and its key
    typedef struct packed {
        logic [31:0]        tag;
        logic signed [31:0] key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_PUSH,
        DP_SCAN,
        DP_SHIFT_INIT,
        DP_SHIFT,
        DP_CHANGE,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic [1:0] kind;
        logic       empty;
        logic       sweep_done;
    } t_dp_stat;

endpackage

// File: sv/min_priority_queue_decrease_key_unit.sv
// Push, unused kind and empty extract give their result beat without a sweep; a key change
//   and a non-empty extract sweep the entries, one entry RAM access per cycle.
// Throughput: one command at a time; the next is taken in the cycle its result shows.
// Reset (synchronous, active low) empties the queue and zeroes the command counter;
//   entry RAM is not cleared. The receiver cannot stall: o_strobe lasts one cycle.
// ----------------------------------------------------------------------------
// min_priority_queue_decrease_key_unit : min-priority queue with key change
// Signed 32-bit keys held in push order in one entry RAM, each tagged with the
// number of the command that pushed it. Extract returns the oldest smallest key.
// ----------------------------------------------------------------------------
module min_priority_queue_decrease_key_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  mpq_pkg::t_in  i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output mpq_pkg::t_out o_result
);
    import mpq_pkg::*;

    // controller <-> datapath: command out, status back
    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    // Controller: idle -> decode -> idle, or via scan -> shift or via change back to idle.
    // A command beat is taken in idle; the result beat shows while the
    // controller is idle again, so a new command can land in that cycle.
    mpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (dp_stat),
        .o_op     (dp_op),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // Datapath: the extract scan reads every entry once and keeps the first
    // strict minimum, then entries above it are moved down by one slot. A key
    // change reads every entry and rewrites the key wherever the tag matches.
    mpq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (dp_op),
        .i_cmd    (i_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

    // result beats never come back to back
    a_strobe_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // a taken command always makes the unit busy
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but unit not busy");

    // a result beat only appears once the command has finished
    a_strobe_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while still busy");

    // key field is zero unless a minimum is returned
    a_key_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != STATUS_MIN)) |-> (o_result.min_key == '0))
        else $error("non-zero key without a minimum");

endmodule

// File: sv/mpq_ram.sv
// ----------------------------------------------------------------------------
// mpq_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/mpq_dp.sv
// ----------------------------------------------------------------------------
// mpq_dp : queue datapath
// Entry RAM, fill count, command counter, sweep counter and min search.
// ----------------------------------------------------------------------------
module mpq_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mpq_pkg::t_dp_op i_op,
    input  mpq_pkg::t_in    i_cmd,
    output mpq_pkg::t_dp_stat o_stat,
    output mpq_pkg::t_out   o_result
);
    import mpq_pkg::*;

    logic [CNT_W-1:0]   r_count,    n_count;
    logic [31:0]        r_cmd_num,  n_cmd_num;
    t_in                r_in,       n_in;
    logic [CNT_W-1:0]   r_rd_idx,   n_rd_idx;
    logic               r_pend,     n_pend;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]   r_best_idx, n_best_idx;
    logic signed [31:0] r_best_key, n_best_key;
    logic               r_best_vld, n_best_vld;
    t_out               r_res,      n_res;

    logic               sweeping;
    logic               issue;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic [ENTRY_W-1:0] rd_raw;
    t_entry             rd_data;

    assign rd_data  = t_entry'(rd_raw);
    assign sweeping = (i_op == DP_SCAN) || (i_op == DP_SHIFT) || (i_op == DP_CHANGE);
    assign issue    = sweeping && (r_rd_idx < r_count);

    always_comb begin
        n_count    = r_count;
        n_cmd_num  = r_cmd_num;
        n_in       = r_in;
        n_rd_idx   = r_rd_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_best_idx = r_best_idx;
        n_best_key = r_best_key;
        n_best_vld = r_best_vld;
        n_res      = r_res;
        wr_en      = 1'b0;
        wr_addr    = r_pend_idx;
        wr_data    = rd_data;

        if (sweeping) begin
            n_rd_idx   = issue ? r_rd_idx + CNT_W'(1) : r_rd_idx;
            n_pend     = issue;
            n_pend_idx = r_rd_idx[IDX_W-1:0];
        end

        case (i_op)
            DP_ACCEPT: begin
                n_in       = i_cmd;
                n_cmd_num  = r_cmd_num + 32'd1;
                n_rd_idx   = '0;
                n_pend     = 1'b0;
                n_best_vld = 1'b0;
            end
            DP_PUSH: begin
                n_res.min_key = '0;
                if (r_count == CNT_W'(CAPACITY)) begin
                    n_res.status = STATUS_FULL;
                end else begin
                    n_res.status = STATUS_DONE;
                    wr_en        = 1'b1;
                    wr_addr      = r_count[IDX_W-1:0];
                    wr_data.tag  = r_cmd_num;
                    wr_data.key  = r_in.key_value;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            DP_SCAN: begin
                // strict less: the oldest of equal minima stays selected
                if (r_pend && (!r_best_vld || (rd_data.key < r_best_key))) begin
                    n_best_vld = 1'b1;
                    n_best_key = rd_data.key;
                    n_best_idx = r_pend_idx;
                end
            end
            DP_SHIFT_INIT: begin
                n_rd_idx = CNT_W'(r_best_idx) + CNT_W'(1);
                n_pend   = 1'b0;
            end
            DP_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pend_idx - IDX_W'(1);
                end
            end
            DP_CHANGE: begin
                if (r_pend && (rd_data.tag == r_in.target_tag)) begin
                    wr_en       = 1'b1;
                    wr_data.key = r_in.key_value;
                end
            end
            DP_FINISH: begin
                n_res.status  = STATUS_DONE;
                n_res.min_key = '0;
                if (r_in.kind == KIND_EXTRACT) begin
                    if (r_count == '0) begin
                        n_res.status = STATUS_EMPTY;
                    end else begin
                        n_res.status  = STATUS_MIN;
                        n_res.min_key = r_best_key;
                        n_count       = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmd_num <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_cmd_num <= n_cmd_num;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_best_vld <= n_best_vld;
        r_res      <= n_res;
    end

    mpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_raw)
    );

    assign o_stat.kind       = r_in.kind;
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.sweep_done = !(r_rd_idx < r_count) && !r_pend;
    assign o_result          = r_res;

endmodule

// File: sv/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl : queue controller
// Sequences decode, min scan, compaction and key change sweeps.
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mpq_pkg::t_dp_stat i_stat,
    output mpq_pkg::t_dp_op   o_op,
    output logic              o_busy,
    output logic              o_strobe
);
    import mpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_CHANGE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_strobe, n_strobe;
    t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op      = DP_ACCEPT;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_PUSH: begin
                        op      = DP_PUSH;
                        n_state = S_IDLE;
                    end
                    KIND_EXTRACT: begin
                        if (i_stat.empty) begin
                            op      = DP_FINISH;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    KIND_CHANGE: begin
                        n_state = S_CHANGE;
                    end
                    default: begin
                        op      = DP_FINISH;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.sweep_done) begin
                    op      = DP_SHIFT_INIT;
                    n_state = S_SHIFT;
                end else begin
                    op = DP_SCAN;
                end
            end
            S_SHIFT: begin
                if (i_stat.sweep_done) begin
                    op      = DP_FINISH;
                    n_state = S_IDLE;
                end else begin
                    op = DP_SHIFT;
                end
            end
            S_CHANGE: begin
                if (i_stat.sweep_done) begin
                    op      = DP_FINISH;
                    n_state = S_IDLE;
                end else begin
                    op = DP_CHANGE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_strobe = (op == DP_PUSH) || (op == DP_FINISH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != S_IDLE);
            r_strobe <= n_strobe;
        end
    end

    assign o_op     = op;
    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule
